// ===== design/hcpg_pkg.sv =====
package hcpg_pkg;

   localparam int NUM_OSC = 4;
   localparam int FRAC_BITS = 16;
   localparam int IDX_W = $clog2(NUM_OSC);
   localparam int CORDIC_STEPS = 24;
   localparam int CNT_W = $clog2(CORDIC_STEPS);

   typedef logic signed [23:0] amp_type;
   typedef logic [19:0] phase_type;
   typedef logic signed [21:0] angle_type;
   typedef logic signed [15:0] force_type;
   typedef logic signed [17:0] foot_type;
   typedef logic signed [17:0] trig_type;
   typedef logic signed [56:0] prod_type;
   typedef logic signed [41:0] wide_type;

   typedef struct packed {
      logic [1:0] gait;
      logic [2:0] mode;
      logic [22:0] swing;
      logic [22:0] stance;
      logic [17:0] gain;
      logic [15:0] step;
      logic [15:0] clear;
      logic [15:0] pen;
   } cfg_type;

   typedef struct packed {
      logic start;
      logic restart;
      logic commit;
   } lane_ctrl_type;

   typedef enum logic [2:0] {
      CSR_GAIT = 3'd0,
      CSR_MODE = 3'd1,
      CSR_SWING = 3'd2,
      CSR_STANCE = 3'd3,
      CSR_GAIN = 3'd4,
      CSR_STEP = 3'd5,
      CSR_CLEAR = 3'd6,
      CSR_PEN = 3'd7
   } csr_index_type;

   localparam angle_type PI = 22'sd205887;
   localparam angle_type TWO_PI = 22'sd411775;
   localparam angle_type HALF_PI = 22'sd102944;
   localparam angle_type THREE_HALF_PI = 22'sd308831;
   localparam amp_type SEED = 24'sd655;
   localparam int ONE = 1 << FRAC_BITS;
   localparam logic [12:0] FORCE_GAIN = 13'd3277;
   localparam logic [12:0] COUPLED_GAIN = 13'd6554;
   localparam logic [19:0] HALF_DT = 20'd536871;
   localparam int HEIGHT = 16384;
   localparam logic [23:0] CORDIC_GAIN = 24'd10188014;

   localparam logic [1:0] OFFSET_Q [4][4][4] = '{
      '{'{2'd0, 2'd0, 2'd2, 2'd2}, '{2'd0, 2'd0, 2'd2, 2'd2},
        '{2'd2, 2'd2, 2'd0, 2'd0}, '{2'd2, 2'd2, 2'd0, 2'd0}},
      '{'{2'd0, 2'd2, 2'd2, 2'd0}, '{2'd2, 2'd0, 2'd0, 2'd2},
        '{2'd2, 2'd0, 2'd0, 2'd2}, '{2'd0, 2'd2, 2'd2, 2'd0}},
      '{'{2'd0, 2'd2, 2'd1, 2'd3}, '{2'd2, 2'd0, 2'd3, 2'd1},
        '{2'd3, 2'd1, 2'd0, 2'd2}, '{2'd1, 2'd3, 2'd2, 2'd0}},
      '{'{2'd0, 2'd2, 2'd0, 2'd2}, '{2'd2, 2'd0, 2'd2, 2'd0},
        '{2'd0, 2'd2, 2'd0, 2'd2}, '{2'd2, 2'd0, 2'd2, 2'd0}}
   };

   localparam logic LINKS [4][4][4] = '{
      '{'{1'b0, 1'b0, 1'b1, 1'b1}, '{1'b0, 1'b0, 1'b1, 1'b1},
        '{1'b1, 1'b1, 1'b0, 1'b0}, '{1'b1, 1'b1, 1'b0, 1'b0}},
      '{'{1'b0, 1'b1, 1'b1, 1'b0}, '{1'b1, 1'b0, 1'b0, 1'b1},
        '{1'b1, 1'b0, 1'b0, 1'b1}, '{1'b0, 1'b1, 1'b1, 1'b0}},
      '{'{1'b0, 1'b1, 1'b1, 1'b0}, '{1'b1, 1'b0, 1'b0, 1'b1},
        '{1'b1, 1'b0, 1'b0, 1'b1}, '{1'b0, 1'b1, 1'b1, 1'b0}},
      '{'{1'b0, 1'b1, 1'b0, 1'b1}, '{1'b1, 1'b0, 1'b1, 1'b0},
        '{1'b0, 1'b1, 1'b0, 1'b1}, '{1'b1, 1'b0, 1'b1, 1'b0}}
   };

   function automatic phase_type quarter_angle(input logic [1:0] q);
      phase_type r;
      case (q)
         2'd1: r = phase_type'(HALF_PI);
         2'd2: r = phase_type'(PI);
         2'd3: r = phase_type'(THREE_HALF_PI);
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic [23:0] atan_q24(input logic [CNT_W-1:0] i);
      logic [23:0] r;
      case (i)
         5'd0: r = 24'd13176795;
         5'd1: r = 24'd7778716;
         5'd2: r = 24'd4110060;
         5'd3: r = 24'd2086331;
         5'd4: r = 24'd1047214;
         5'd5: r = 24'd524117;
         5'd6: r = 24'd262123;
         5'd7: r = 24'd131069;
         5'd8: r = 24'd65536;
         5'd9: r = 24'd32768;
         5'd10: r = 24'd16384;
         5'd11: r = 24'd8192;
         5'd12: r = 24'd4096;
         5'd13: r = 24'd2048;
         5'd14: r = 24'd1024;
         5'd15: r = 24'd512;
         5'd16: r = 24'd256;
         5'd17: r = 24'd128;
         5'd18: r = 24'd64;
         5'd19: r = 24'd32;
         5'd20: r = 24'd16;
         5'd21: r = 24'd8;
         5'd22: r = 24'd4;
         5'd23: r = 24'd2;
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic wide_type rnd_frac(input prod_type v);
      logic signed [57:0] t;
      t = 58'(v) + 58'(ONE / 2);
      return wide_type'(t >>> FRAC_BITS);
   endfunction

   function automatic logic signed [26:0] rnd_dt(input prod_type v);
      logic signed [57:0] t;
      t = 58'(v) + 58'sd536870912;
      return 27'(t >>> 30);
   endfunction

   function automatic amp_type sat24(input wide_type v);
      amp_type r;
      if (v > 42'sd8388607) begin
         r = 24'sd8388607;
      end else if (v < -42'sd8388608) begin
         r = -24'sd8388608;
      end else begin
         r = amp_type'(v);
      end
      return r;
   endfunction

   function automatic foot_type sat18(input wide_type v);
      foot_type r;
      if (v > 42'sd131071) begin
         r = 18'sd131071;
      end else if (v < -42'sd131072) begin
         r = -18'sd131072;
      end else begin
         r = foot_type'(v);
      end
      return r;
   endfunction

endpackage

// ===== design/hopf_cpg_gait_generator.sv =====
// Gait generator made of four coupled Hopf oscillators, one per leg.
// Each request beat carries four foot forces and a restart flag; it advances
// every oscillator by one 1 ms step and returns one response beat with the
// foot x and height targets of all four legs.
// The four oscillators run as parallel lanes, each with its own multiplier
// and its own 24-step CORDIC unit; the lanes then hand their results to an
// output register that swaps the legs of each pair.
// The response time depends on the mode: it is longest with coupling and both
// force terms enabled, shorter with coupling alone and shortest with coupling off.
// The CORDIC runs of each lane (up to six) account for most of that time.
// One beat is worked on at a time; the next request is taken in the cycle after
// the lanes have handed over, even while the response still waits to be taken.
// If the receiver stalls, the finished lanes hold their result and the
// oscillator state is not updated until the response register is free.
// Configuration writes are taken at any time and should only be made while
// the block is idle. Reset loads the default registers, the amplitude seed,
// the first row of the bound gait's phase table and zero rates.
module hopf_cpg_gait_generator
   import hcpg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_restart,
   input  force_type   req_force_leg0,
   input  force_type   req_force_leg1,
   input  force_type   req_force_leg2,
   input  force_type   req_force_leg3,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output foot_type    rsp_foot_x_leg0,
   output foot_type    rsp_foot_x_leg1,
   output foot_type    rsp_foot_x_leg2,
   output foot_type    rsp_foot_x_leg3,
   output foot_type    rsp_foot_z_leg0,
   output foot_type    rsp_foot_z_leg1,
   output foot_type    rsp_foot_z_leg2,
   output foot_type    rsp_foot_z_leg3,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [22:0] csr_data
);

   typedef enum logic [1:0] {
      T_IDLE = 2'b01,
      T_RUN  = 2'b10
   } top_state_type;

   top_state_type state_ff, state_in;
   cfg_type cfg_ff;
   force_type force_ff [NUM_OSC];
   amp_type lane_amp [NUM_OSC];
   phase_type lane_phase [NUM_OSC];
   foot_type lane_x [NUM_OSC];
   foot_type lane_z [NUM_OSC];
   logic [NUM_OSC-1:0] lane_done;
   lane_ctrl_type ctrl;
   logic all_done, out_free, accept;
   logic rsp_valid_ff;
   foot_type rsp_x_ff [4];
   foot_type rsp_z_ff [4];

   assign accept = req_valid && req_ready;
   assign all_done = &lane_done;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == T_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      ctrl.start = accept;
      ctrl.restart = req_restart;
      ctrl.commit = (state_ff == T_RUN) && all_done && out_free;
      state_in = state_ff;
      case (state_ff)
         T_IDLE: begin
            if (accept) begin
               state_in = T_RUN;
            end
         end
         T_RUN: begin
            if (ctrl.commit) begin
               state_in = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   for (genvar k = 0; k < NUM_OSC; k++) begin : g_lane
      hcpg_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .lane_idx  (IDX_W'(k)),
         .ctrl      (ctrl),
         .cfg       (cfg_ff),
         .force_all (force_ff),
         .amp_all   (lane_amp),
         .phase_all (lane_phase),
         .amp_out   (lane_amp[k]),
         .phase_out (lane_phase[k]),
         .done      (lane_done[k]),
         .foot_x    (lane_x[k]),
         .foot_z    (lane_z[k])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
         rsp_valid_ff <= 1'b0;
         cfg_ff.gait <= 2'd0;
         cfg_ff.mode <= 3'd3;
         cfg_ff.swing <= 23'd2058874;
         cfg_ff.stance <= 23'd535307;
         cfg_ff.gain <= 18'd65536;
         cfg_ff.step <= 16'd3277;
         cfg_ff.clear <= 16'd4588;
         cfg_ff.pen <= 16'd655;
      end else begin
         state_ff <= state_in;
         if (ctrl.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_GAIT: cfg_ff.gait <= csr_data[1:0];
               CSR_MODE: cfg_ff.mode <= csr_data[2:0];
               CSR_SWING: cfg_ff.swing <= csr_data;
               CSR_STANCE: cfg_ff.stance <= csr_data;
               CSR_GAIN: cfg_ff.gain <= csr_data[17:0];
               CSR_STEP: cfg_ff.step <= csr_data[15:0];
               CSR_CLEAR: cfg_ff.clear <= csr_data[15:0];
               CSR_PEN: cfg_ff.pen <= csr_data[15:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         force_ff[0] <= req_force_leg0;
         force_ff[1] <= req_force_leg1;
         force_ff[2] <= req_force_leg2;
         force_ff[3] <= req_force_leg3;
      end
      if (ctrl.commit) begin
         for (int k = 0; k < 4; k++) begin
            rsp_x_ff[k] <= lane_x[(k ^ 1) % NUM_OSC];
            rsp_z_ff[k] <= lane_z[(k ^ 1) % NUM_OSC];
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_foot_x_leg0 = rsp_x_ff[0];
   assign rsp_foot_x_leg1 = rsp_x_ff[1];
   assign rsp_foot_x_leg2 = rsp_x_ff[2];
   assign rsp_foot_x_leg3 = rsp_x_ff[3];
   assign rsp_foot_z_leg0 = rsp_z_ff[0];
   assign rsp_foot_z_leg1 = rsp_z_ff[1];
   assign rsp_foot_z_leg2 = rsp_z_ff[2];
   assign rsp_foot_z_leg3 = rsp_z_ff[3];

`ifndef NO_ASSERTIONS
   a_start_lanes_idle: assert property (@(posedge clock) disable iff (reset)
      accept |-> (lane_done == '0))
      else $error("A beat was taken while a lane still held a result.");

   a_commit_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      ctrl.commit |=> rsp_valid)
      else $error("Lane hand-over did not raise the response.");

   a_rsp_from_lanes: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(all_done))
      else $error("Response raised before every lane had finished.");
`endif

endmodule

// ===== design/hcpg_cordic.sv =====
module hcpg_cordic
   import hcpg_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   input  angle_type angle,
   output logic      done,
   output trig_type  sin_out,
   output trig_type  cos_out
);

   logic signed [27:0] x_ff, y_ff, z_ff;
   logic signed [27:0] x_in, y_in, z_in, z_start;
   logic [CNT_W-1:0] cnt_ff;
   logic busy_ff, done_ff, flip_ff, flip_start;
   angle_type a1, a2, a3, a4;
   logic signed [27:0] dx, dy, at;
   logic signed [27:0] sr, cr;

   always_comb begin
      a1 = (angle < 0) ? angle + TWO_PI : angle;
      a2 = (a1 < 0) ? a1 + TWO_PI : a1;
      a3 = (a2 > PI) ? a2 - TWO_PI : a2;
      flip_start = 1'b0;
      a4 = a3;
      if (a3 > HALF_PI) begin
         a4 = PI - a3;
         flip_start = 1'b1;
      end else if (a3 < -HALF_PI) begin
         a4 = -PI - a3;
         flip_start = 1'b1;
      end
      z_start = 28'(a4) <<< 8;
      dx = y_ff >>> cnt_ff;
      dy = x_ff >>> cnt_ff;
      at = 28'(atan_q24(cnt_ff));
      if (z_ff >= 0) begin
         x_in = x_ff - dx;
         y_in = y_ff + dy;
         z_in = z_ff - at;
      end else begin
         x_in = x_ff + dx;
         y_in = y_ff - dy;
         z_in = z_ff + at;
      end
      sr = (y_ff + 28'sd128) >>> 8;
      cr = (x_ff + 28'sd128) >>> 8;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(CORDIC_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff <= 28'(CORDIC_GAIN);
         y_ff <= '0;
         z_ff <= z_start;
         flip_ff <= flip_start;
      end else if (busy_ff) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign done = done_ff;
   assign sin_out = trig_type'(sr);
   assign cos_out = flip_ff ? -trig_type'(cr) : trig_type'(cr);

endmodule

// ===== design/hcpg_lane.sv =====
module hcpg_lane
   import hcpg_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] lane_idx,
   input  lane_ctrl_type    ctrl,
   input  cfg_type          cfg,
   input  force_type        force_all [NUM_OSC],
   input  amp_type          amp_all [NUM_OSC],
   input  phase_type        phase_all [NUM_OSC],
   output amp_type          amp_out,
   output phase_type        phase_out,
   output logic             done,
   output foot_type         foot_x,
   output foot_type         foot_z
);

   typedef enum logic [20:0] {
      S_IDLE = 21'h000001,
      S_RR   = 21'h000002,
      S_AR   = 21'h000004,
      S_AR2  = 21'h000008,
      S_CK   = 21'h000010,
      S_CW   = 21'h000020,
      S_CA   = 21'h000040,
      S_FC   = 21'h000080,
      S_FW   = 21'h000100,
      S_FM   = 21'h000200,
      S_FA   = 21'h000400,
      S_LF   = 21'h000800,
      S_DA   = 21'h001000,
      S_DP   = 21'h002000,
      S_PH   = 21'h004000,
      S_OC   = 21'h008000,
      S_OW   = 21'h010000,
      S_OX   = 21'h020000,
      S_OZ   = 21'h040000,
      S_OXF  = 21'h080000,
      S_DONE = 21'h100000
   } lane_state_type;

   lane_state_type state_ff, state_in;
   amp_type amp_ff, par_ff, ppr_ff, amp_rate_ff, ph_rate_ff, new_amp_ff;
   phase_type phase_ff, new_phase_ff;
   logic signed [33:0] om_ff;
   prod_type p_ff, mul_p;
   logic signed [32:0] mul_a;
   logic signed [23:0] mul_b;
   logic p_load;
   logic [IDX_W-1:0] j_ff;
   logic signed [24:0] xs_ff;
   foot_type x_ff, z_ff;
   logic cord_start, cord_done;
   angle_type cord_angle, wrap_sum;
   trig_type cord_sin, cord_cos;
   wide_type frac_p;
   logic [15:0] lift;

   hcpg_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cord_start),
      .angle   (cord_angle),
      .done    (cord_done),
      .sin_out (cord_sin),
      .cos_out (cord_cos)
   );

   always_comb begin
      frac_p = rnd_frac(p_ff);
      lift = (cord_sin > 0) ? cfg.clear : cfg.pen;
      wrap_sum = angle_type'({2'b00, phase_ff}) + 22'(rnd_dt(p_ff));
      if (wrap_sum < 0) begin
         wrap_sum = wrap_sum + TWO_PI;
      end else if (wrap_sum >= TWO_PI) begin
         wrap_sum = wrap_sum - TWO_PI;
      end
      cord_start = 1'b0;
      cord_angle = angle_type'({2'b00, phase_ff});
      mul_a = '0;
      mul_b = '0;
      p_load = 1'b0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (ctrl.start) begin
               state_in = S_RR;
            end
         end
         S_RR: begin
            mul_a = 33'(amp_ff);
            mul_b = amp_ff;
            p_load = 1'b1;
            state_in = S_AR;
         end
         S_AR: begin
            mul_a = 33'(ONE) - 33'(frac_p);
            mul_b = amp_ff;
            p_load = 1'b1;
            state_in = S_AR2;
         end
         S_AR2: begin
            state_in = cfg.mode[0] ? S_CK : S_DA;
         end
         S_CK: begin
            mul_a = 33'(amp_all[j_ff]);
            mul_b = 24'(cfg.gain);
            p_load = 1'b1;
            cord_start = 1'b1;
            cord_angle = angle_type'({2'b00, phase_all[j_ff]}) - angle_type'({2'b00, phase_ff})
                       - angle_type'({2'b00, quarter_angle(OFFSET_Q[cfg.gait][lane_idx][j_ff])});
            state_in = S_CW;
         end
         S_CW: begin
            mul_a = 33'(frac_p);
            mul_b = 24'(cord_sin);
            if (cord_done) begin
               p_load = 1'b1;
               state_in = S_CA;
            end
         end
         S_CA: begin
            if (j_ff == IDX_W'(NUM_OSC - 1)) begin
               if (cfg.mode[1]) begin
                  state_in = S_FC;
               end else if (cfg.mode[2]) begin
                  state_in = S_LF;
               end else begin
                  state_in = S_DA;
               end
            end else begin
               state_in = S_CK;
            end
         end
         S_FC: begin
            cord_start = 1'b1;
            state_in = S_FW;
         end
         S_FW: begin
            mul_a = 33'(force_all[lane_idx ^ IDX_W'(1)]);
            mul_b = 24'(cord_cos);
            if (cord_done) begin
               p_load = 1'b1;
               state_in = S_FM;
            end
         end
         S_FM: begin
            mul_a = p_ff[32:0];
            mul_b = 24'(FORCE_GAIN);
            p_load = 1'b1;
            state_in = S_FA;
         end
         S_FA: begin
            state_in = cfg.mode[2] ? S_LF : S_DA;
         end
         S_LF: begin
            if (j_ff == IDX_W'(NUM_OSC - 1)) begin
               state_in = S_DA;
            end
         end
         S_DA: begin
            mul_a = 33'(par_ff) + 33'(amp_rate_ff);
            mul_b = 24'(HALF_DT);
            p_load = 1'b1;
            state_in = S_DP;
         end
         S_DP: begin
            mul_a = 33'(ppr_ff) + 33'(ph_rate_ff);
            mul_b = 24'(HALF_DT);
            p_load = 1'b1;
            state_in = S_PH;
         end
         S_PH: begin
            state_in = S_OC;
         end
         S_OC: begin
            cord_start = 1'b1;
            cord_angle = angle_type'({2'b00, new_phase_ff});
            state_in = S_OW;
         end
         S_OW: begin
            mul_a = 33'(new_amp_ff);
            mul_b = 24'(cord_cos);
            if (cord_done) begin
               p_load = 1'b1;
               state_in = S_OX;
            end
         end
         S_OX: begin
            mul_a = 33'(lift);
            mul_b = 24'(cord_sin);
            p_load = 1'b1;
            state_in = S_OZ;
         end
         S_OZ: begin
            mul_a = 33'(xs_ff);
            mul_b = 24'(cfg.step);
            p_load = 1'b1;
            state_in = S_OXF;
         end
         S_OXF: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (ctrl.commit) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      mul_p = 57'(mul_a) * 57'(mul_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         amp_ff <= SEED;
         phase_ff <= quarter_angle(OFFSET_Q[0][0][lane_idx]);
         par_ff <= '0;
         ppr_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_IDLE && ctrl.start && ctrl.restart) begin
            amp_ff <= SEED;
            phase_ff <= quarter_angle(OFFSET_Q[cfg.gait][0][lane_idx]);
            par_ff <= '0;
            ppr_ff <= '0;
         end else if (state_ff == S_DONE && ctrl.commit) begin
            amp_ff <= new_amp_ff;
            phase_ff <= new_phase_ff;
            par_ff <= amp_rate_ff;
            ppr_ff <= ph_rate_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (p_load) begin
         p_ff <= mul_p;
      end
      case (state_ff)
         S_AR2: begin
            amp_rate_ff <= sat24(frac_p * 42'sd5);
            om_ff <= (phase_ff > phase_type'(PI)) ? 34'(cfg.stance) : 34'(cfg.swing);
            j_ff <= '0;
         end
         S_CA: begin
            om_ff <= om_ff + 34'(frac_p);
            j_ff <= j_ff + 1'b1;
         end
         S_FA: begin
            om_ff <= om_ff - 34'(frac_p);
         end
         S_LF: begin
            if (LINKS[cfg.gait][lane_idx][j_ff]) begin
               om_ff <= om_ff + 34'(force_all[j_ff ^ IDX_W'(1)] * $signed({1'b0, COUPLED_GAIN}));
            end
            j_ff <= j_ff + 1'b1;
         end
         S_DA: begin
            ph_rate_ff <= sat24(42'(om_ff));
         end
         S_DP: begin
            new_amp_ff <= sat24(42'(amp_ff) + 42'(rnd_dt(p_ff)));
         end
         S_PH: begin
            new_phase_ff <= wrap_sum[19:0];
         end
         S_OX: begin
            xs_ff <= 25'(frac_p);
         end
         S_OZ: begin
            z_ff <= sat18(frac_p - 42'(HEIGHT));
         end
         S_OXF: begin
            x_ff <= sat18(-frac_p);
         end
         default: begin
         end
      endcase
   end

   assign amp_out = amp_ff;
   assign phase_out = phase_ff;
   assign done = (state_ff == S_DONE);
   assign foot_x = x_ff;
   assign foot_z = z_ff;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import hcpg_pkg::*;

   localparam int LIMIT = 3000000;
   localparam int SETTLE = 400;

   typedef struct {
      logic restart;
      force_type f[4];
   } tick_type;

   typedef struct {
      foot_type x[4];
      foot_type z[4];
   } foot_set_type;

   localparam longint ATAN_TAB[24] = '{
      13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
      256, 128, 64, 32, 16, 8, 4, 2};

   logic clock, reset;
   logic req_valid, req_ready, req_restart;
   force_type req_force_leg0, req_force_leg1, req_force_leg2, req_force_leg3;
   logic rsp_valid, rsp_ready;
   foot_type rsp_foot_x_leg0, rsp_foot_x_leg1, rsp_foot_x_leg2, rsp_foot_x_leg3;
   foot_type rsp_foot_z_leg0, rsp_foot_z_leg1, rsp_foot_z_leg2, rsp_foot_z_leg3;
   logic csr_valid, csr_ready;
   logic [2:0] csr_index;
   logic [22:0] csr_data;

   tick_type pending_ticks[$];
   foot_set_type expected_feet[$];
   tick_type cur_tick;
   logic req_done;
   int send_idle, recv_stall;
   int cycles, errors;

   longint gait_sel, fb_mode, swing_freq, stance_freq, gain, step_len, clear_h, pen_h;
   longint amp[4], ph[4], prev_ar[4], prev_pr[4];

   hopf_cpg_gait_generator DUT (.*);

   function automatic longint rnd_shift(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint sat_to(longint v, int bits);
      longint hi;
      hi = (longint'(1) << (bits - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   function automatic longint wrap_phase(longint a);
      longint r;
      r = a % longint'(TWO_PI);
      if (r < 0) r += longint'(TWO_PI);
      return r;
   endfunction

   function automatic longint quarter_turn(logic [1:0] q);
      case (q)
         2'd1: return longint'(HALF_PI);
         2'd2: return longint'(PI);
         2'd3: return longint'(THREE_HALF_PI);
         default: return 0;
      endcase
   endfunction

   task automatic trig(input longint ang, output longint s, output longint c);
      longint a, x, y, z, dx, dy;
      bit flip;
      a = wrap_phase(ang);
      x = 10188014;
      y = 0;
      flip = 0;
      if (a > longint'(PI)) a -= longint'(TWO_PI);
      if (a > longint'(HALF_PI)) begin
         a = longint'(PI) - a;
         flip = 1;
      end else if (a < -longint'(HALF_PI)) begin
         a = -longint'(PI) - a;
         flip = 1;
      end
      z = a * 256;
      for (int i = 0; i < 24; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= ATAN_TAB[i];
         end else begin
            x += dx; y -= dy; z += ATAN_TAB[i];
         end
      end
      s = rnd_shift(y, 8);
      c = rnd_shift(x, 8);
      if (flip) c = -c;
   endtask

   function automatic void load_seed();
      for (int i = 0; i < 4; i++) begin
         amp[i] = longint'(SEED);
         ph[i] = quarter_turn(OFFSET_Q[gait_sel][0][i]);
         prev_ar[i] = 0;
         prev_pr[i] = 0;
      end
   endfunction

   task automatic advance_gait(input tick_type t, output foot_set_type res);
      longint frc[4], ar[4], pr[4], xs[4], zs[4];
      longint r, phi, fi, r2, om, ang, k, s, c, da, dp, lift;
      for (int i = 0; i < 4; i++) frc[i] = longint'(t.f[i]);
      if (t.restart) load_seed();
      for (int i = 0; i < 4; i++) begin
         r = amp[i];
         phi = ph[i];
         fi = frc[i ^ 1];
         r2 = rnd_shift(r * r, 16);
         om = (phi > longint'(PI)) ? stance_freq : swing_freq;
         ar[i] = sat_to(5 * rnd_shift((65536 - r2) * r, 16), 24);
         if (fb_mode[0]) begin
            for (int j = 0; j < 4; j++) begin
               ang = ph[j] - phi - quarter_turn(OFFSET_Q[gait_sel][i][j]);
               k = rnd_shift(amp[j] * gain, 16);
               trig(ang, s, c);
               om += rnd_shift(k * s, 16);
            end
            if (fb_mode[1]) begin
               trig(phi, s, c);
               om -= rnd_shift(fi * c * 3277, 16);
            end
            if (fb_mode[2]) begin
               for (int j = 0; j < 4; j++)
                  if (LINKS[gait_sel][i][j]) om += 6554 * frc[j ^ 1];
            end
         end
         pr[i] = sat_to(om, 24);
      end
      for (int i = 0; i < 4; i++) begin
         da = rnd_shift((prev_ar[i] + ar[i]) * 536871, 30);
         dp = rnd_shift((prev_pr[i] + pr[i]) * 536871, 30);
         amp[i] = sat_to(amp[i] + da, 24);
         ph[i] = wrap_phase(ph[i] + dp);
         prev_ar[i] = ar[i];
         prev_pr[i] = pr[i];
         trig(ph[i], s, c);
         xs[i] = rnd_shift(amp[i] * c, 16);
         lift = (s > 0) ? clear_h : pen_h;
         zs[i] = rnd_shift(lift * s, 16) - 16384;
      end
      for (int i = 0; i < 4; i++) begin
         res.x[i] = foot_type'(sat_to(-rnd_shift(step_len * xs[i ^ 1], 16), 18));
         res.z[i] = foot_type'(sat_to(zs[i ^ 1], 18));
      end
   endtask

   function automatic void apply_csr(csr_index_type idx, logic [22:0] d);
      case (idx)
         CSR_GAIT: gait_sel = d[1:0];
         CSR_MODE: fb_mode = d[2:0];
         CSR_SWING: swing_freq = d;
         CSR_STANCE: stance_freq = d;
         CSR_GAIN: gain = d[17:0];
         CSR_STEP: step_len = d[15:0];
         CSR_CLEAR: clear_h = d[15:0];
         CSR_PEN: pen_h = d[15:0];
         default: begin
         end
      endcase
   endfunction

   task automatic csr_write(input csr_index_type idx, input logic [22:0] d);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= d;
      do @(posedge clock); while (!csr_ready);
      apply_csr(idx, d);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [22:0] pick(logic [22:0] hi);
      case ($urandom_range(0, 3))
         0: return '0;
         1: return hi;
         default: return 23'($urandom) & hi;
      endcase
   endfunction

   task automatic push_tick(input logic rs, input int a, input int b, input int c, input int d);
      tick_type t;
      t.restart = rs;
      t.f[0] = force_type'(a);
      t.f[1] = force_type'(b);
      t.f[2] = force_type'(c);
      t.f[3] = force_type'(d);
      pending_ticks.push_back(t);
   endtask

   task automatic drain();
      while (!(pending_ticks.size() == 0 && !req_valid && expected_feet.size() == 0))
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_done)) begin
         if (pending_ticks.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
            cur_tick = pending_ticks.pop_front();
            req_valid <= 1'b1;
            req_restart <= cur_tick.restart;
            req_force_leg0 <= cur_tick.f[0];
            req_force_leg1 <= cur_tick.f[1];
            req_force_leg2 <= cur_tick.f[2];
            req_force_leg3 <= cur_tick.f[3];
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready <= reset ? 1'b0 : ($urandom_range(0, 99) >= recv_stall);
   end

   always @(posedge clock) begin
      tick_type t;
      foot_set_type e, got;
      bit same;
      req_done <= req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         t.restart = req_restart;
         t.f[0] = req_force_leg0;
         t.f[1] = req_force_leg1;
         t.f[2] = req_force_leg2;
         t.f[3] = req_force_leg3;
         advance_gait(t, e);
         expected_feet.push_back(e);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         got.x = '{rsp_foot_x_leg0, rsp_foot_x_leg1, rsp_foot_x_leg2, rsp_foot_x_leg3};
         got.z = '{rsp_foot_z_leg0, rsp_foot_z_leg1, rsp_foot_z_leg2, rsp_foot_z_leg3};
         if (expected_feet.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response beat at cycle %0d", cycles);
         end else begin
            e = expected_feet.pop_front();
            same = 1'b1;
            for (int i = 0; i < 4; i++) begin
               if (got.x[i] !== e.x[i] || got.z[i] !== e.z[i]) same = 1'b0;
            end
            if (!same) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch cycle %0d: x exp %p got %p, z exp %p got %p",
                           cycles, e.x, got.x, e.z, got.z);
            end
         end
      end
   end

   initial begin
      cycles = 0;
      errors = 0;
      send_idle = 0;
      recv_stall = 0;
      req_done = 1'b0;
      req_valid = 1'b0;
      req_restart = 1'b0;
      req_force_leg0 = '0;
      req_force_leg1 = '0;
      req_force_leg2 = '0;
      req_force_leg3 = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      gait_sel = 0; fb_mode = 3; swing_freq = 2058874; stance_freq = 535307;
      gain = 65536; step_len = 3277; clear_h = 4588; pen_h = 655;
      load_seed();
      reset = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      push_tick(0, 0, 0, 0, 0);
      push_tick(0, 32767, 32767, 32767, 32767);
      push_tick(0, -32768, -32768, -32768, -32768);
      push_tick(0, 32767, -32768, 32767, -32768);
      push_tick(1, 0, 0, 0, 0);
      push_tick(0, 1, -1, 100, -100);
      for (int i = 0; i < 12; i++) push_tick(0, 0, 0, 0, 0);
      push_tick(1, -32768, 32767, -32768, 32767);
      drain();

      csr_write(CSR_MODE, 23'd7);
      csr_write(CSR_GAIN, 23'h3FFFF);
      csr_write(CSR_SWING, 23'h7FFFFF);
      csr_write(CSR_STANCE, 23'h7FFFFF);
      csr_write(CSR_STEP, 23'hFFFF);
      csr_write(CSR_CLEAR, 23'hFFFF);
      csr_write(CSR_PEN, 23'hFFFF);
      csr_write(CSR_GAIT, 23'd2);
      push_tick(1, 32767, 32767, -32768, -32768);
      for (int i = 0; i < 5; i++)
         push_tick(0, $urandom, $urandom, $urandom, $urandom);
      drain();

      for (int p = 0; p < 8; p++) begin
         csr_write(CSR_GAIT, 23'($urandom) & ~23'd3 | 23'(p % 4));
         csr_write(CSR_MODE, 23'($urandom) & ~23'd7 | 23'(p == 7 ? 7 : p));
         csr_write(CSR_SWING, pick(23'h7FFFFF));
         csr_write(CSR_STANCE, pick(23'h7FFFFF));
         csr_write(CSR_GAIN, pick(23'h3FFFF));
         csr_write(CSR_STEP, pick(23'hFFFF));
         csr_write(CSR_CLEAR, pick(23'hFFFF));
         csr_write(CSR_PEN, pick(23'hFFFF));
         case (p % 4)
            0: begin send_idle = 0; recv_stall = 0; end
            1: begin send_idle = 58; recv_stall = 0; end
            2: begin send_idle = 0; recv_stall = 58; end
            default: begin send_idle = 10; recv_stall = 10; end
         endcase
         push_tick(1, 0, 0, 0, 0);
         for (int i = 0; i < 200; i++) begin
            if ($urandom_range(0, 1))
               push_tick($urandom_range(0, 99) < 3, $urandom, $urandom, $urandom, $urandom);
            else
               push_tick(0, $urandom_range(0, 4000) - 2000, $urandom_range(0, 4000) - 2000,
                         $urandom_range(0, 4000) - 2000, $urandom_range(0, 4000) - 2000);
         end
         drain();
      end

      if (errors == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/hcpg_pkg.sv
design/hcpg_cordic.sv
design/hcpg_lane.sv
design/hopf_cpg_gait_generator.sv
bench/tb.sv
